>>> rtl/core/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// Types, constants and the dimming table shared by the lamp controller core.
// ----------------------------------------------------------------------------
package lbd_pkg;

   localparam int unsigned SINCE_W   = 17;
   localparam int unsigned ELAPSED_W = 24;
   localparam int unsigned STEP_W    = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 24;

   localparam logic [SINCE_W-1:0]   SINCE_MAX   = '1;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
   localparam logic [STEP_W-1:0]    DIM_LAST    = 5'd18;
   localparam logic [7:0]           TAG_LAMP    = 8'd76;
   localparam logic [6:0]           MIN_LENGTH  = 7'd7;

   localparam logic [7:0]  RST_LAMP_ADDRESS = 8'd49;
   localparam logic [15:0] RST_BUTTON_DELAY = 16'd250;
   localparam logic [23:0] RST_AUTO_OFF     = 24'd1200000;
   localparam logic [7:0]  RST_COLOR        = 8'd255;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_RADIO = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LAMP_ADDRESS = 2'd0,
      CSR_BUTTON_DELAY = 2'd1,
      CSR_AUTO_OFF     = 2'd2
   } lbd_csr_type;

   typedef struct packed {
      logic [7:0]  lamp_address;
      logic [15:0] button_delay_ms;
      logic [23:0] auto_off_ms;
   } lbd_cfg_type;

   typedef struct packed {
      logic       kind;
      logic       button_pressed;
      logic       crc_ok;
      logic [6:0] packet_length;
      logic [7:0] packet_tag;
      logic [7:0] packet_address;
      logic [7:0] cmd_red;
      logic [7:0] cmd_green;
      logic [7:0] cmd_blue;
   } lbd_item_type;

   typedef struct packed {
      logic [SINCE_W-1:0]   since_check_ms;
      logic                 held;
      logic                 toggle_pending;
      logic                 dim_rising;
      logic [STEP_W-1:0]    dim_step;
      logic                 is_on;
      logic [7:0]           color_red;
      logic [7:0]           color_green;
      logic [7:0]           color_blue;
      logic                 off_timer_armed;
      logic [ELAPSED_W-1:0] on_elapsed_ms;
   } lbd_state_type;

   typedef struct packed {
      logic [7:0] drive_red;
      logic [7:0] drive_green;
      logic [7:0] drive_blue;
      logic       lamp_lit;
      logic       announce;
   } lbd_result_type;

   localparam lbd_state_type STATE_RESET = '{
      since_check_ms:  SINCE_MAX,
      held:            1'b0,
      toggle_pending:  1'b0,
      dim_rising:      1'b0,
      dim_step:        DIM_LAST,
      is_on:           1'b1,
      color_red:       RST_COLOR,
      color_green:     RST_COLOR,
      color_blue:      RST_COLOR,
      off_timer_armed: 1'b1,
      on_elapsed_ms:   '0
   };

   function automatic logic [7:0] dim_level(input logic [STEP_W-1:0] step);
      logic [7:0] level;
      case (step)
         5'd0:    level = 8'd1;
         5'd1:    level = 8'd2;
         5'd2:    level = 8'd3;
         5'd3:    level = 8'd4;
         5'd4:    level = 8'd6;
         5'd5:    level = 8'd8;
         5'd6:    level = 8'd11;
         5'd7:    level = 8'd16;
         5'd8:    level = 8'd22;
         5'd9:    level = 8'd31;
         5'd10:   level = 8'd44;
         5'd11:   level = 8'd62;
         5'd12:   level = 8'd87;
         5'd13:   level = 8'd123;
         5'd14:   level = 8'd173;
         default: level = 8'd255;
      endcase
      return level;
   endfunction

endpackage

>>> rtl/core/lamp_button_dimmer_controller_core.sv
// ----------------------------------------------------------------------------
// lamp_button_dimmer_controller_core
// RGB lamp controller: button toggle and dimming, auto-off, radio commands.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  req     | req_valid / req_ready  | kind, button, frame fields
//  rsp     | rsp_valid / rsp_ready  | drive_red/green/blue, lamp_lit, announce
//  csr     | csr_write_enable       | csr_index, csr_write_data
//
//  rsp follows req acceptance through the input register, then the
//  state update and result register in one pass. One transaction per cycle
//  while rsp is not stalled. Reset restores config, valid flags and lamp
//  state; no clearing pass. A stalled rsp holds the input register;
//  req_ready drops only when both stages are full and rsp_ready is low.
// ----------------------------------------------------------------------------
module lamp_button_dimmer_controller_core
   import lbd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic                 req_button_pressed,
   input  logic                 req_crc_ok,
   input  logic [6:0]           req_packet_length,
   input  logic [7:0]           req_packet_tag,
   input  logic [7:0]           req_packet_address,
   input  logic [7:0]           req_cmd_red,
   input  logic [7:0]           req_cmd_green,
   input  logic [7:0]           req_cmd_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_drive_red,
   output logic [7:0]           rsp_drive_green,
   output logic [7:0]           rsp_drive_blue,
   output logic                 rsp_lamp_lit,
   output logic                 rsp_announce,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_write_data
);

   lbd_cfg_type    cfg_ff;
   lbd_state_type  state_ff;
   lbd_state_type  state_in;
   lbd_item_type   item_ff;
   lbd_item_type   item_in;
   lbd_result_type result_ff;
   lbd_result_type result_in;
   logic           item_valid_ff;
   logic           rsp_valid_ff;
   logic           advance;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   assign item_in = '{
      kind:           req_kind,
      button_pressed: req_button_pressed,
      crc_ok:         req_crc_ok,
      packet_length:  req_packet_length,
      packet_tag:     req_packet_tag,
      packet_address: req_packet_address,
      cmd_red:        req_cmd_red,
      cmd_green:      req_cmd_green,
      cmd_blue:       req_cmd_blue
   };

   lbd_step u_step (
      .state_cur (state_ff),
      .item      (item_ff),
      .cfg       (cfg_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lamp_address    <= RST_LAMP_ADDRESS;
         cfg_ff.button_delay_ms <= RST_BUTTON_DELAY;
         cfg_ff.auto_off_ms     <= RST_AUTO_OFF;
      end else if (csr_write_enable) begin
         case (lbd_csr_type'(csr_index))
            CSR_LAMP_ADDRESS: cfg_ff.lamp_address    <= csr_write_data[7:0];
            CSR_BUTTON_DELAY: cfg_ff.button_delay_ms <= csr_write_data[15:0];
            CSR_AUTO_OFF:     cfg_ff.auto_off_ms     <= csr_write_data[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= STATE_RESET;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_red   = result_ff.drive_red;
   assign rsp_drive_green = result_ff.drive_green;
   assign rsp_drive_blue  = result_ff.drive_blue;
   assign rsp_lamp_lit    = result_ff.lamp_lit;
   assign rsp_announce    = result_ff.announce;

endmodule

>>> rtl/core/lbd_step.sv
// ----------------------------------------------------------------------------
// lbd_step
// Next-state and result logic for one transaction: button tick or radio frame.
// ----------------------------------------------------------------------------
module lbd_step
   import lbd_pkg::*;
(
   input  lbd_state_type  state_cur,
   input  lbd_item_type   item,
   input  lbd_cfg_type    cfg,
   output lbd_state_type  state_nxt,
   output lbd_result_type result
);

   logic announce;
   logic frame_ok;

   assign frame_ok = item.crc_ok && (item.packet_length >= MIN_LENGTH) &&
                     (item.packet_tag == TAG_LAMP) &&
                     (item.packet_address == cfg.lamp_address);

   always_comb begin
      lbd_state_type s;
      logic [7:0]    level;
      logic          past_delay;
      s          = state_cur;
      announce   = 1'b0;
      level      = '0;
      past_delay = 1'b0;
      if (item.kind == KIND_TICK) begin
         if (s.since_check_ms != SINCE_MAX) begin
            s.since_check_ms = s.since_check_ms + 1'b1;
         end
         if (s.off_timer_armed && (s.on_elapsed_ms != ELAPSED_MAX)) begin
            s.on_elapsed_ms = s.on_elapsed_ms + 1'b1;
         end
         past_delay = s.since_check_ms > {1'b0, cfg.button_delay_ms};
         if (item.button_pressed) begin
            if (past_delay) begin
               if (s.held) begin
                  s.toggle_pending = 1'b0;
                  if (s.dim_step >= DIM_LAST) begin
                     s.dim_rising = 1'b0;
                  end
                  if (s.dim_step == '0) begin
                     s.dim_rising = 1'b1;
                  end
                  if (s.dim_rising) begin
                     s.dim_step = s.dim_step + 1'b1;
                  end else begin
                     s.dim_step = s.dim_step - 1'b1;
                  end
                  level             = dim_level(s.dim_step);
                  s.color_red       = level;
                  s.color_green     = level;
                  s.color_blue      = level;
                  s.is_on           = 1'b1;
                  s.off_timer_armed = 1'b1;
                  s.on_elapsed_ms   = '0;
                  announce          = 1'b1;
               end else begin
                  s.toggle_pending = 1'b1;
               end
               s.held           = 1'b1;
               s.since_check_ms = '0;
            end
         end else if (s.held && past_delay) begin
            if (s.toggle_pending) begin
               if (s.is_on) begin
                  s.is_on           = 1'b0;
                  s.off_timer_armed = 1'b0;
               end else begin
                  s.is_on           = 1'b1;
                  s.off_timer_armed = 1'b1;
                  s.on_elapsed_ms   = '0;
               end
               announce = 1'b1;
            end else begin
               s.dim_rising = !s.dim_rising;
            end
            s.held = 1'b0;
         end
         if (s.off_timer_armed && (s.on_elapsed_ms > cfg.auto_off_ms)) begin
            s.is_on           = 1'b0;
            s.off_timer_armed = 1'b0;
            announce          = 1'b1;
         end
      end else if (frame_ok) begin
         if ((item.cmd_red != '0) && (item.cmd_green != '0) && (item.cmd_blue != '0)) begin
            s.color_red       = item.cmd_red;
            s.color_green     = item.cmd_green;
            s.color_blue      = item.cmd_blue;
            s.is_on           = 1'b1;
            s.off_timer_armed = 1'b1;
            s.on_elapsed_ms   = '0;
         end else begin
            s.is_on           = 1'b0;
            s.off_timer_armed = 1'b0;
         end
         announce = 1'b1;
      end
      state_nxt = s;
   end

   assign result.drive_red   = state_nxt.is_on ? state_nxt.color_red   : 8'd0;
   assign result.drive_green = state_nxt.is_on ? state_nxt.color_green : 8'd0;
   assign result.drive_blue  = state_nxt.is_on ? state_nxt.color_blue  : 8'd0;
   assign result.lamp_lit    = state_nxt.is_on;
   assign result.announce    = announce;

endmodule

>>> rtl/core/lbd_checker.sv
// ----------------------------------------------------------------------------
// lbd_checker
// Port-level checks for the lamp controller core, bound to the top level.
// ----------------------------------------------------------------------------
module lbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_drive_red,
   input logic [7:0] rsp_drive_green,
   input logic [7:0] rsp_drive_blue,
   input logic       rsp_lamp_lit,
   input logic       rsp_announce
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transaction");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_drive_red, rsp_drive_green,
                                           rsp_drive_blue, rsp_lamp_lit,
                                           rsp_announce}))
      else $error("rsp payload changed while stalled");

   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_lamp_lit |->
         (rsp_drive_red == 8'd0) && (rsp_drive_green == 8'd0) &&
         (rsp_drive_blue == 8'd0))
      else $error("lamp off but drive nonzero");

   a_on_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lamp_lit |->
         (rsp_drive_red != 8'd0) && (rsp_drive_green != 8'd0) &&
         (rsp_drive_blue != 8'd0))
      else $error("lamp on with a dark channel");

endmodule

bind lamp_button_dimmer_controller_core lbd_checker u_lbd_checker (.*);
